// ----- sv/idft_pkg.sv -----
// Shared types and constants of the inverse 2D DFT accumulator.
package idft_pkg;

  localparam int KIND_W    = 2;
  localparam int FREQ_W    = 7;
  localparam int COEF_W    = 16;
  localparam int PIX_W     = 6;
  localparam int OUT_W     = 24;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int ACC_W     = 40;
  localparam int PHASE_W   = 16;
  localparam int SIN_W     = 16;
  localparam int CT_W      = 18;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_COEF  = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b1;
  localparam logic [CFG_W-1:0]     DIM_RESET      = 7'd64;

  // largest |frequency| a 7-bit signed field can hold
  localparam logic [FREQ_W-1:0] FREQ_MAG_MAX = 7'd64;

  localparam logic [ACC_W-1:0] OUT_POS_MAX = 40'd8388607;
  localparam logic [ACC_W-1:0] OUT_NEG_MAX = 40'd8388608;

endpackage

// ----- sv/idft_in_if.sv -----
// Request channel carrying clear, coefficient and read requests.
interface idft_in_if;
  import idft_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [FREQ_W-1:0]   freq_row;
  logic signed [FREQ_W-1:0]   freq_col;
  logic signed [COEF_W-1:0]   coef_real;
  logic signed [COEF_W-1:0]   coef_imag;
  logic [PIX_W-1:0]           pixel_row;
  logic [PIX_W-1:0]           pixel_col;
  modport source (output valid, kind, freq_row, freq_col, coef_real, coef_imag,
                  pixel_row, pixel_col, input ready);
  modport sink   (input valid, kind, freq_row, freq_col, coef_real, coef_imag,
                  pixel_row, pixel_col, output ready);
endinterface

// ----- sv/idft_out_if.sv -----
// Result channel carrying normalized pixel values.
interface idft_out_if;
  import idft_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  pixel_value;
  modport source (output valid, pixel_value, input ready);
  modport sink   (input valid, pixel_value, output ready);
endinterface

// ----- sv/idft_cfg_if.sv -----
// Register write channel.
interface idft_cfg_if;
  import idft_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/idft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module idft_ram #(
  parameter int W     = 40,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- sv/idft_div_cell.sv -----
// One cell of the phase divider chain: one quotient bit per cell.
module idft_div_cell #(
  parameter int DW = 13,
  parameter int AW = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [DW-1:0]               den_i,
  input  logic                        valid_i,
  input  logic [AW-1:0]               addr_i,
  input  logic [DW-1:0]               rem_i,
  input  logic [idft_pkg::PHASE_W-1:0] quo_i,
  output logic                        valid_o,
  output logic [AW-1:0]               addr_o,
  output logic [DW-1:0]               rem_o,
  output logic [idft_pkg::PHASE_W-1:0] quo_o
);
  import idft_pkg::*;

  logic [DW:0]          rem2;
  logic                 ge;
  logic                 valid_q;
  logic [AW-1:0]        addr_q;
  logic [DW-1:0]        rem_q;
  logic [PHASE_W-1:0]   quo_q;

  assign rem2 = {rem_i, 1'b0};
  assign ge   = rem2 >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_i;
    rem_q  <= ge ? DW'(rem2 - {1'b0, den_i}) : DW'(rem2);
    quo_q  <= {quo_i[PHASE_W-2:0], ge};
  end

  assign valid_o = valid_q;
  assign addr_o  = addr_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
endmodule

// ----- sv/idft_sine.sv -----
// Quarter-wave sine/cosine lookup of a 16-bit phase, registered Q15 output.
module idft_sine #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic [idft_pkg::PHASE_W-1:0]     phase_i,
  output logic signed [idft_pkg::SIN_W-1:0] sin_o,
  output logic signed [idft_pkg::SIN_W-1:0] cos_o
);
  import idft_pkg::*;

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MW = 14 + IW;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned TaylorDiv [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  function automatic logic [SIN_W-2:0] sine_entry(input int unsigned i);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x    = HalfPiQ30 * 64'(i) / SINE_TABLE_DEPTH;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TaylorDiv[n-1];
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return (SIN_W-1)'(sum);
  endfunction

  logic [SIN_W-2:0] rom [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    assign rom[g] = sine_entry(g);
  end

  logic [PHASE_W-1:0]     cph;
  logic [IW-1:0]          sidx;
  logic [IW-1:0]          cidx;
  logic [SIN_W-2:0]       smag;
  logic [SIN_W-2:0]       cmag;
  logic signed [SIN_W-1:0] sin_q;
  logic signed [SIN_W-1:0] cos_q;

  assign cph  = phase_i + PHASE_W'(16'h4000);
  assign sidx = IW'((MW'(phase_i[13:0]) * MW'(SINE_TABLE_DEPTH)) >> 14);
  assign cidx = IW'((MW'(cph[13:0]) * MW'(SINE_TABLE_DEPTH)) >> 14);
  assign smag = phase_i[14] ? rom[IW'(SINE_TABLE_DEPTH) - sidx] : rom[sidx];
  assign cmag = cph[14] ? rom[IW'(SINE_TABLE_DEPTH) - cidx] : rom[cidx];

  always_ff @(posedge clk_i) begin
    sin_q <= phase_i[15] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
    cos_q <= cph[15] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule

// ----- sv/inverse_dft_2d_accumulator.sv -----
// Direct 2D inverse DFT accumulator (real part), top level.
//
//  channel  | dir | payload                                      | when taken
//  cfg_i    | in  | index, data                                  | any time
//  in_i     | in  | kind, freq_row/col, coef_real/imag, pixel_*  | block idle
//  out_o    | out | pixel_value                                  | read results
//
// Coefficient: a setup pass, a sweep of rows*cols pixels (one pixel per cycle through a
// 16-cell phase divider chain), then a drain of the pixel pipeline. Zero coefficient: no setup or sweep.
// Clear: one RAM word per cycle over all MAX_ROWS*MAX_COLS words; the same pass runs after reset
// before the first request is taken. Read: the result is formed by a bit-serial divider.
// A waiting result holds in the output register; a read waits only for that register.
module inverse_dft_2d_accumulator #(
  parameter int MAX_ROWS         = 64,
  parameter int MAX_COLS         = 64,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  idft_cfg_if.sink   cfg_i,
  idft_in_if.sink    in_i,
  idft_out_if.source out_o
);
  import idft_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(DEPTH + 1);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int PIPE_DRAIN = PHASE_W + 8;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_SWEEP  = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_RDWAIT = 3'd5;
  localparam logic [2:0] ST_RDDIV  = 3'd6;
  localparam logic [2:0] ST_RDOUT  = 3'd7;

  function automatic logic [DW-1:0] mod_add(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                            input logic [DW-1:0] m);
    logic [DW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[DW-1:0];
  endfunction

  // configuration
  logic [CFG_W-1:0] rows_q, cols_q;
  logic [RCW-1:0]   rows_c;
  logic [CCW-1:0]   cols_c;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_RESET;
      cols_q <= DIM_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_IMAGE_ROWS) rows_q <= cfg_i.data;
      if (cfg_i.index == REG_IMAGE_COLS) cols_q <= cfg_i.data;
    end
  end

  assign rows_c = (rows_q == '0) ? RCW'(1) :
                  (32'(rows_q) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_q);
  assign cols_c = (cols_q == '0) ? CCW'(1) :
                  (32'(cols_q) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_q);

  // control and item state
  logic [2:0]        st_q, st_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [6:0]        sc_q, sc_d;
  logic [RCW-1:0]    rws_q, rws_d;
  logic [CCW-1:0]    cls_q, cls_d;
  logic [DW-1:0]     den_q, den_d;
  logic signed [COEF_W-1:0] re_q, re_d, im_q, im_d;
  logic [FREQ_W-1:0] fka_q, fka_d, fla_q, fla_d;
  logic              fkn_q, fkn_d, fln_q, fln_d;
  logic [DW-1:0]     a_q, a_d, b_q, b_d;
  logic [RCW-1:0]    k_q, k_d;
  logic [CCW-1:0]    l_q, l_d;
  logic [DW-1:0]     r_q, r_d, rrow_q, rrow_d;
  logic [AW-1:0]     addr_q, addr_d, arow_q, arow_d;
  logic              zero_q, zero_d, neg_q, neg_d;
  logic [ACC_W-1:0]  n_q, n_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  logic              in_acc;
  logic [AW-1:0]     rd_addr;
  logic              rd_oob;
  logic [ACC_W-1:0]  rd_val, rd_mag;
  logic [DW:0]       div_r2;
  logic              div_ge;
  logic [OUT_W-1:0]  sat_val;

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ACC_W-1:0]  ram_wdata, ram_rdata;

  // pixel pipeline
  logic              ch_v    [PHASE_W+1];
  logic [AW-1:0]     ch_addr [PHASE_W+1];
  logic [DW-1:0]     ch_rem  [PHASE_W+1];
  logic [PHASE_W-1:0] ch_quo [PHASE_W+1];
  logic signed [SIN_W-1:0] sin_w, cos_w;
  logic              v1_q, v2_q, v3_q, v4_q;
  logic [AW-1:0]     addr1_q, addr2_q, addr3_q, addr4_q;
  logic signed [31:0] pr_q, pi_q;
  logic signed [32:0] psum;
  logic signed [CT_W-1:0] ct3_q, ct4_q;

  assign in_i.ready = (st_q == ST_IDLE);
  assign in_acc     = in_i.valid && (st_q == ST_IDLE);

  assign rd_oob  = (32'(in_i.pixel_row) >= MAX_ROWS) || (32'(in_i.pixel_col) >= MAX_COLS);
  assign rd_addr = AW'(32'(in_i.pixel_row) * MAX_COLS + 32'(in_i.pixel_col));
  assign rd_val  = zero_q ? '0 : ram_rdata;
  assign rd_mag  = rd_val[ACC_W-1] ? (~rd_val + ACC_W'(1)) : rd_val;
  assign div_r2  = {rem_q, n_q[ACC_W-1]};
  assign div_ge  = div_r2 >= {1'b0, den_q};

  always_comb begin
    if (!neg_q) begin
      sat_val = (n_q > OUT_POS_MAX) ? OUT_W'(OUT_POS_MAX) : OUT_W'(n_q);
    end else begin
      sat_val = (n_q > OUT_NEG_MAX) ? OUT_W'(~OUT_NEG_MAX + ACC_W'(1))
                                    : OUT_W'(~n_q + ACC_W'(1));
    end
  end

  always_comb begin
    st_d = st_q;   clr_d = clr_q;   sc_d = sc_q;
    rws_d = rws_q; cls_d = cls_q;   den_d = den_q;
    re_d = re_q;   im_d = im_q;
    fka_d = fka_q; fla_d = fla_q;   fkn_d = fkn_q; fln_d = fln_q;
    a_d = a_q;     b_d = b_q;
    k_d = k_q;     l_d = l_q;       r_d = r_q;     rrow_d = rrow_q;
    addr_d = addr_q; arow_d = arow_q;
    zero_d = zero_q; neg_d = neg_q; n_d = n_q;     rem_d = rem_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          rws_d = rows_c;
          cls_d = cols_c;
          den_d = DW'(32'(rows_c) * 32'(cols_c));
          case (in_i.kind)
            KIND_CLEAR: begin
              clr_d = '0;
              st_d  = ST_CLEAR;
            end
            KIND_COEF: begin
              re_d  = in_i.coef_real;
              im_d  = in_i.coef_imag;
              fkn_d = in_i.freq_row[FREQ_W-1];
              fln_d = in_i.freq_col[FREQ_W-1];
              fka_d = fkn_d ? FREQ_W'(-in_i.freq_row) : FREQ_W'(in_i.freq_row);
              fla_d = fln_d ? FREQ_W'(-in_i.freq_col) : FREQ_W'(in_i.freq_col);
              a_d   = '0;
              b_d   = '0;
              sc_d  = '0;
              if (in_i.coef_real != '0 || in_i.coef_imag != '0) st_d = ST_SETUP;
            end
            KIND_READ: begin
              zero_d = rd_oob;
              st_d   = ST_RDWAIT;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) st_d = ST_IDLE;
      end
      ST_SETUP: begin
        if (sc_q == FREQ_MAG_MAX) begin
          if (fkn_q && a_q != '0) a_d = den_q - a_q;
          if (fln_q && b_q != '0) b_d = den_q - b_q;
          k_d = '0; l_d = '0; r_d = '0; rrow_d = '0; addr_d = '0; arow_d = '0;
          st_d = ST_SWEEP;
        end else begin
          if (sc_q < fka_q) a_d = mod_add(a_q, DW'(cls_q), den_q);
          if (sc_q < fla_q) b_d = mod_add(b_q, DW'(rws_q), den_q);
          sc_d = sc_q + 7'd1;
        end
      end
      ST_SWEEP: begin
        if (l_q == cls_q - CCW'(1)) begin
          if (k_q == rws_q - RCW'(1)) begin
            sc_d = '0;
            st_d = ST_DRAIN;
          end else begin
            k_d    = k_q + RCW'(1);
            l_d    = '0;
            rrow_d = mod_add(rrow_q, a_q, den_q);
            r_d    = rrow_d;
            arow_d = arow_q + AW'(MAX_COLS);
            addr_d = arow_d;
          end
        end else begin
          l_d    = l_q + CCW'(1);
          r_d    = mod_add(r_q, b_q, den_q);
          addr_d = addr_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        sc_d = sc_q + 7'd1;
        if (sc_q == 7'(PIPE_DRAIN - 1)) st_d = ST_IDLE;
      end
      ST_RDWAIT: begin
        neg_d = rd_val[ACC_W-1];
        n_d   = rd_mag + ACC_W'(den_q >> 1);
        rem_d = '0;
        sc_d  = '0;
        st_d  = ST_RDDIV;
      end
      ST_RDDIV: begin
        rem_d = div_ge ? DW'(div_r2 - {1'b0, den_q}) : DW'(div_r2);
        n_d   = {n_q[ACC_W-2:0], div_ge};
        sc_d  = sc_q + 7'd1;
        if (sc_q == 7'(ACC_W - 1)) st_d = ST_RDOUT;
      end
      ST_RDOUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = sat_val;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      sc_q        <= '0;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      sc_q        <= sc_d;
      out_valid_q <= out_valid_d;
      v1_q        <= ch_v[PHASE_W];
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rws_q <= rws_d;   cls_q <= cls_d;   den_q <= den_d;
    re_q <= re_d;     im_q <= im_d;
    fka_q <= fka_d;   fla_q <= fla_d;   fkn_q <= fkn_d; fln_q <= fln_d;
    a_q <= a_d;       b_q <= b_d;
    k_q <= k_d;       l_q <= l_d;       r_q <= r_d;     rrow_q <= rrow_d;
    addr_q <= addr_d; arow_q <= arow_d;
    zero_q <= zero_d; neg_q <= neg_d;   n_q <= n_d;     rem_q <= rem_d;
    out_data_q <= out_data_d;
    addr1_q <= ch_addr[PHASE_W];
    addr2_q <= addr1_q;
    addr3_q <= addr2_q;
    addr4_q <= addr3_q;
    pr_q    <= re_q * cos_w;
    pi_q    <= im_q * sin_w;
    ct3_q   <= psum[32:15];
    ct4_q   <= ct3_q;
  end

  // phase = floor(((den - r) mod den) * 2^16 / den), one bit per cell
  assign ch_v[0]    = (st_q == ST_SWEEP);
  assign ch_addr[0] = addr_q;
  assign ch_rem[0]  = (r_q == '0) ? '0 : den_q - r_q;
  assign ch_quo[0]  = '0;

  for (genvar g = 0; g < PHASE_W; g++) begin : g_chain
    idft_div_cell #(.DW(DW), .AW(AW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .den_i   (den_q),
      .valid_i (ch_v[g]),
      .addr_i  (ch_addr[g]),
      .rem_i   (ch_rem[g]),
      .quo_i   (ch_quo[g]),
      .valid_o (ch_v[g+1]),
      .addr_o  (ch_addr[g+1]),
      .rem_o   (ch_rem[g+1]),
      .quo_o   (ch_quo[g+1])
    );
  end

  idft_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
    .clk_i   (clk_i),
    .phase_i (ch_quo[PHASE_W]),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  assign psum = 33'(pr_q) + 33'(pi_q) + 33'sd16384;

  assign ram_raddr = (st_q == ST_IDLE) ? rd_addr : addr3_q;
  assign ram_we    = (st_q == ST_CLEAR) || v4_q;
  assign ram_waddr = (st_q == ST_CLEAR) ? clr_q : addr4_q;
  assign ram_wdata = (st_q == ST_CLEAR) ? '0 : ram_rdata + ACC_W'(ct4_q);

  idft_ram #(.W(ACC_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_value = out_data_q;

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_IDLE |-> !v4_q && !v3_q)
    else $error("pixel pipeline busy while idle");

  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == ST_RDOUT)
    else $error("result raised outside read completion");

  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RDWAIT || st_q == ST_RDDIV || st_q == ST_RDOUT) |-> !ram_we)
    else $error("accumulator written during readout");
endmodule
